// ----- hw/rtl/twbs_pkg.sv -----
// Package for the ticket work bonus scoring unit.
// Holds the field widths, bonus constants, register indexes and helper functions.
// It depends on nothing else.
package twbs_pkg;

  localparam int HashWordW = 64;
  localparam int WordLzW   = 7;
  localparam int CountW    = 8;
  localparam int DiffW     = 8;
  localparam int CapW      = 14;
  localparam int BonusW    = 13;
  localparam int SpanW     = 9;
  localparam int SqrtW     = 5;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 14;

  localparam logic [BonusW-1:0]   BonusBaseBps  = 13'd500;
  localparam logic [BonusW-1:0]   BonusStepBps  = 13'd400;
  localparam logic [CapW-1:0]     BonusCapReset = 14'd2500;
  localparam logic [CountW-1:0]   CountSat      = 8'd255;
  localparam logic [BonusW-1:0]   BonusMaxBps   = 13'd6900;

  localparam logic [CfgIdxW-1:0] CFG_DIFFICULTY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BONUS_CAP  = 2'd1;

  // Leading zeros of a nonzero byte, most significant bit first.
  function automatic logic [2:0] lz8(input logic [7:0] x);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) begin
        r = 3'(7 - i);
      end
    end
    return r;
  endfunction

  // Floor of the square root for spans from 1 to 256.
  function automatic logic [SqrtW-1:0] isqrt9(input logic [SpanW-1:0] x);
    logic [SqrtW-1:0] r;
    r = '0;
    for (int k = 1; k <= 16; k++) begin
      if (x >= SpanW'(k * k)) begin
        r = SqrtW'(k);
      end
    end
    return r;
  endfunction

  typedef struct packed {
    logic [WordLzW-1:0] lz0;
    logic [WordLzW-1:0] lz1;
    logic [WordLzW-1:0] lz2;
    logic [WordLzW-1:0] lz3;
  } word_lz_t;

  typedef struct packed {
    logic [CountW-1:0] zero_count;
    logic              meets;
    logic [SpanW-1:0]  span;
  } count_stage_t;

  typedef struct packed {
    logic [CountW-1:0] zero_count;
    logic              meets;
    logic [BonusW-1:0] raw_bps;
  } raw_stage_t;

endpackage

// ----- hw/rtl/twbs_in_if.sv -----
// Input channel of the scoring unit: one 256-bit hash per beat.
// Depends on twbs_pkg for the word width.
interface twbs_in_if
  import twbs_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [HashWordW-1:0] hash_word0;
  logic [HashWordW-1:0] hash_word1;
  logic [HashWordW-1:0] hash_word2;
  logic [HashWordW-1:0] hash_word3;

  modport source (output valid, hash_word0, hash_word1, hash_word2, hash_word3, input ready);
  modport sink   (input valid, hash_word0, hash_word1, hash_word2, hash_word3, output ready);
  modport monitor (input valid, ready, hash_word0, hash_word1, hash_word2, hash_word3);
endinterface

// ----- hw/rtl/twbs_out_if.sv -----
// Result channel of the scoring unit: one score per beat.
// Depends on twbs_pkg for the field widths.
interface twbs_out_if
  import twbs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] zero_count;
  logic              meets;
  logic [BonusW-1:0] bonus_bps;

  modport source (output valid, zero_count, meets, bonus_bps, input ready);
  modport sink   (input valid, zero_count, meets, bonus_bps, output ready);
  modport monitor (input valid, ready, zero_count, meets, bonus_bps);
endinterface

// ----- hw/rtl/ticket_work_bonus_scoring_unit.sv -----
// Ticket work bonus scoring unit: top level with the configuration registers and the pipeline.
// Depends on twbs_pkg, twbs_in_if, twbs_out_if and twbs_clz64.
//
// Each hash beat is scored in a four-stage pipeline: per-word leading zero counts, the combined
// count with the difficulty check, the square root lookup with the raw bonus, and the cap on the
// output register. A new hash is taken every cycle while the result side does not stall; a stall
// holds the output register and every full stage up to the first empty one. in_hash.ready is
// high while any stage has room. Configuration writes take effect at once and are meant for an
// empty pipeline.
module ticket_work_bonus_scoring_unit
  import twbs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  twbs_in_if.sink             in_hash,
  twbs_out_if.source          out_score,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  logic [DiffW-1:0] difficulty_r;
  logic [CapW-1:0]  bonus_cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      difficulty_r <= '0;
      bonus_cap_r  <= BonusCapReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIFFICULTY: difficulty_r <= cfg_wdata[DiffW-1:0];
        CFG_BONUS_CAP:  bonus_cap_r  <= cfg_wdata[CapW-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and the ready chain from the result side back to the input.
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic s1_load, s2_load, s3_load, out_load;

  assign out_load      = !out_valid_r || out_score.ready;
  assign s3_load       = !s3_valid_r || out_load;
  assign s2_load       = !s2_valid_r || s3_load;
  assign s1_load       = !s1_valid_r || s2_load;
  assign in_hash.ready = s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load)  s1_valid_r  <= in_hash.valid;
      if (s2_load)  s2_valid_r  <= s1_valid_r;
      if (s3_load)  s3_valid_r  <= s2_valid_r;
      if (out_load) out_valid_r <= s3_valid_r;
    end
  end

  // Stage 1: leading zeros of each word.
  word_lz_t s1_nxt, s1_r;

  twbs_clz64 u_clz0 (.word(in_hash.hash_word0), .lz(s1_nxt.lz0));
  twbs_clz64 u_clz1 (.word(in_hash.hash_word1), .lz(s1_nxt.lz1));
  twbs_clz64 u_clz2 (.word(in_hash.hash_word2), .lz(s1_nxt.lz2));
  twbs_clz64 u_clz3 (.word(in_hash.hash_word3), .lz(s1_nxt.lz3));

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_r <= s1_nxt;
    end
  end

  // Stage 2: combined count, difficulty check and the span for the square root.
  count_stage_t s2_nxt, s2_r;

  always_comb begin
    if (!s1_r.lz0[6]) begin
      s2_nxt.zero_count = {2'd0, s1_r.lz0[5:0]};
    end else if (!s1_r.lz1[6]) begin
      s2_nxt.zero_count = {2'd1, s1_r.lz1[5:0]};
    end else if (!s1_r.lz2[6]) begin
      s2_nxt.zero_count = {2'd2, s1_r.lz2[5:0]};
    end else if (!s1_r.lz3[6]) begin
      s2_nxt.zero_count = {2'd3, s1_r.lz3[5:0]};
    end else begin
      s2_nxt.zero_count = CountSat;
    end
    s2_nxt.meets = (s2_nxt.zero_count >= difficulty_r);
    s2_nxt.span  = SpanW'(s2_nxt.zero_count) - SpanW'(difficulty_r) + SpanW'(1);
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_r <= s2_nxt;
    end
  end

  // Stage 3: square root of the span and the uncapped bonus.
  raw_stage_t       s3_nxt, s3_r;
  logic [SqrtW-1:0] root;

  always_comb begin
    root              = isqrt9(s2_r.span);
    s3_nxt.zero_count = s2_r.zero_count;
    s3_nxt.meets      = s2_r.meets;
    s3_nxt.raw_bps    = BonusBaseBps + BonusStepBps * BonusW'(root);
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_r <= s3_nxt;
    end
  end

  // Stage 4: cap and output register.
  logic [CountW-1:0] zero_count_r;
  logic              meets_r;
  logic [BonusW-1:0] bonus_r, bonus_nxt;

  always_comb begin
    if (!s3_r.meets) begin
      bonus_nxt = '0;
    end else if ({1'b0, s3_r.raw_bps} < bonus_cap_r) begin
      bonus_nxt = s3_r.raw_bps;
    end else begin
      bonus_nxt = bonus_cap_r[BonusW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      zero_count_r <= s3_r.zero_count;
      meets_r      <= s3_r.meets;
      bonus_r      <= bonus_nxt;
    end
  end

  assign out_score.valid      = out_valid_r;
  assign out_score.zero_count = zero_count_r;
  assign out_score.meets      = meets_r;
  assign out_score.bonus_bps  = bonus_r;

endmodule

// ----- hw/rtl/twbs_clz64.sv -----
// Leading zero counter for one 64-bit hash word; reports 64 for an all-zero word.
// Depends on twbs_pkg for lz8 and the widths.
module twbs_clz64
  import twbs_pkg::*;
(
  input  logic [HashWordW-1:0] word,
  output logic [WordLzW-1:0]   lz
);

  logic [7:0]      byte_nz;
  logic [7:0][2:0] byte_lz;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      byte_nz[b] = |word[63 - 8*b -: 8];
      byte_lz[b] = lz8(word[63 - 8*b -: 8]);
    end
  end

  // The first nonzero byte from the top wins, so byte 0 is checked last.
  always_comb begin
    lz = WordLzW'(64);
    for (int b = 7; b >= 0; b--) begin
      if (byte_nz[b]) begin
        lz = {1'b0, 3'(b), byte_lz[b]};
      end
    end
  end

endmodule

// ----- hw/rtl/twbs_checker.sv -----
// Port-level assertions for the scoring unit, bound to the top level.
// Depends on twbs_pkg and the handshake and result ports of the top level.
module twbs_checker
  import twbs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CountW-1:0] out_zero_count,
  input logic              out_meets,
  input logic [BonusW-1:0] out_bonus_bps
);

  // A result beat that is held back keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_zero_count) && $stable(out_meets)
      && $stable(out_bonus_bps))
    else $error("result beat changed while stalled");

  // With the output register empty, every stage has room for a new hash.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready while output register is empty");

  // A hash that falls short earns nothing and cannot have the saturated count.
  a_short_no_bonus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_meets |->
      out_bonus_bps == '0 && out_zero_count != CountSat)
    else $error("bonus or count wrong for a hash below difficulty");

  // The bonus never exceeds the largest value the formula can give.
  a_bonus_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bonus_bps <= BonusMaxBps)
    else $error("bonus out of range");

endmodule

bind ticket_work_bonus_scoring_unit twbs_checker u_twbs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_hash.ready),
  .out_valid      (out_score.valid),
  .out_ready      (out_score.ready),
  .out_zero_count (out_score.zero_count),
  .out_meets      (out_score.meets),
  .out_bonus_bps  (out_score.bonus_bps)
);
